FILE: hw/rtl/ipd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants of the imagette payload deframer
// Request structs, parse phases, item kinds, status codes and the fixed
// positions of the payload layout.
// ----------------------------------------------------------------------------
package ipd_pkg;

    // Payload layout
    localparam int unsigned DATA_START          = 12;
    localparam int unsigned RECORD_HEADER_BYTES = 6;
    localparam int unsigned STORE_DEPTH         = 65536;

    localparam logic [15:0] COUNT_HI_POS  = 16'd2;
    localparam logic [15:0] COUNT_LO_POS  = 16'd3;
    localparam logic [15:0] TAG_FIRST_POS = 16'd4;
    localparam logic [15:0] TAG_LAST_POS  = 16'd11;
    localparam logic [15:0] HDR_LAST_POS  = 16'(DATA_START - 1);
    localparam logic [15:0] POS_MAX       = 16'hFFFF;

    localparam logic [16:0] DATA_START_POS = 17'(DATA_START);
    localparam logic [17:0] SIZE_BIAS      = 18'(DATA_START - 2);

    // Record header: offset complete after four bytes, item emitted after six
    localparam logic [15:0] OFFSET_BYTES  = 16'(RECORD_HEADER_BYTES - 2);
    localparam logic [15:0] REC_HDR_BYTES = 16'(RECORD_HEADER_BYTES);

    // Store addressing
    localparam logic [16:0] STORE_LIMIT = 17'(STORE_DEPTH);
    localparam logic [16:0] STORE_OVF   = 17'(STORE_DEPTH + 1);

    // Divide by ten: exact for every 32-bit dividend
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int unsigned DIV10_SHIFT = 35;

    // Result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // Item kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_RECHDR = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // End status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RECHDR,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        first_byte;
        logic        final_byte;
        logic [15:0] declared_size;
    } pay_req_t;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [15:0] record_count;
        logic [63:0] tag_value;
        logic [15:0] record_index;
        logic [28:0] offset_ticks;
        logic [15:0] record_length;
        logic [7:0]  data_value;
        logic [15:0] store_address;
        logic [1:0]  status_code;
        logic        last_of_run;
    } res_req_t;

    // Results of one parsed byte, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        res_req_t   first;
        res_req_t   second;
    } push_t;

endpackage

FILE: hw/rtl/imagette_payload_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imagette_payload_deframer: byte-wise parser of imagette command payloads
// Extracts the record count and tag, then each record's offset (divided by
// ten), length and data bytes with running store addresses, and reports an
// end status on the final byte.
// ----------------------------------------------------------------------------
//
//   channel   request        handshake              per request
//   -------   ------------   --------------------   ----------------------
//   payload   pay_req        pay_valid / pay_stall  one payload byte
//   result    res_req        res_valid / res_stall  one header, record,
//                                                   data or status item
//
// One payload byte is taken per cycle while pay_stall is low. The byte is
// held in an input register, parsed in one pass and its results written
// from there into a four-entry result queue, which offers them in order.
// A final byte that also yields a header, record or data item gives two
// results, which leave the single output port one after the other. The
// divide by ten is a reciprocal multiply started on the fifth record-header
// byte and registered before the sixth.
// Reset clears the parse state and empties the queue. pay_stall rises
// only while the queue lacks room for two results.
module imagette_payload_deframer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pay_valid,
    output logic              pay_stall,
    input  ipd_pkg::pay_req_t pay_req,
    output logic              res_valid,
    input  logic              res_stall,
    output ipd_pkg::res_req_t res_req
);

    ipd_pkg::push_t push;
    logic           room;

    // Parse each byte against the stored phase; emit up to two results
    ipd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pay_valid (pay_valid),
        .pay_stall (pay_stall),
        .pay_req   (pay_req),
        .room      (room),
        .push      (push)
    );

    // Hold results until the consumer takes them, one per cycle while res_stall is low
    ipd_result_fifo u_result_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_req   (res_req)
    );

endmodule

FILE: hw/rtl/ipd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_parser: input register and single-pass byte parser
// Holds one payload request, advances the parse state and produces up to
// two result requests for the result queue.
// ----------------------------------------------------------------------------
module ipd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pay_valid,
    output logic              pay_stall,
    input  ipd_pkg::pay_req_t pay_req,
    input  logic              room,
    output ipd_pkg::push_t    push
);

    logic              in_valid_reg;
    ipd_pkg::pay_req_t in_req_reg;
    logic              advance;

    ipd_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [15:0]     pos_reg, pos_next, cur_pos;
    logic [15:0]     rl_reg, rl_next, cur_rl;
    logic [15:0]     rec_reg, rec_next, cur_rec;
    logic [63:0]     acc_reg, acc_next, cur_acc;
    logic [15:0]     bl_reg, bl_next, cur_bl;
    logic [16:0]     wa_reg, wa_next, cur_wa;
    logic [16:0]     rep_reg, rep_next, cur_rep;

    logic [28:0]     quot_reg;
    logic [63:0]     product;
    logic            quot_load;

    logic               finish;
    logic               main_valid;
    ipd_pkg::res_req_t  main_item;
    ipd_pkg::res_req_t  end_item;
    logic [7:0]         b;

    assign advance   = in_valid_reg & room;
    assign pay_stall = in_valid_reg & ~room;
    assign b         = in_req_reg.payload_byte;
    assign product   = {32'd0, acc_reg[31:0]} * {32'd0, ipd_pkg::DIV10_MAGIC};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!pay_stall)
        begin
            in_valid_reg <= pay_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!pay_stall && pay_valid)
        begin
            in_req_reg <= pay_req;
        end
        if (advance && quot_load)
        begin
            quot_reg <= product[ipd_pkg::DIV10_SHIFT +: 29];
        end
    end

    always_comb
    begin
        // Restart the parse from the cleared state on a first byte
        if (in_req_reg.first_byte)
        begin
            cur_phase = ipd_pkg::PH_HEADER;
            cur_pos   = '0;
            cur_rl    = '0;
            cur_rec   = '0;
            cur_acc   = '0;
            cur_bl    = '0;
            cur_wa    = '0;
            cur_rep   = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_pos   = pos_reg;
            cur_rl    = rl_reg;
            cur_rec   = rec_reg;
            cur_acc   = acc_reg;
            cur_bl    = bl_reg;
            cur_wa    = wa_reg;
            cur_rep   = rep_reg;
        end

        pos_next   = (cur_pos != ipd_pkg::POS_MAX) ? cur_pos + 16'd1 : cur_pos;
        phase_next = cur_phase;
        rl_next    = cur_rl;
        rec_next   = cur_rec;
        acc_next   = cur_acc;
        bl_next    = cur_bl;
        wa_next    = cur_wa;
        rep_next   = cur_rep;
        quot_load  = 1'b0;
        finish     = 1'b0;
        main_valid = 1'b0;
        main_item  = '0;
        end_item   = '0;
        push       = '0;

        unique case (cur_phase)
            ipd_pkg::PH_HEADER:
            begin
                if (cur_pos == ipd_pkg::COUNT_HI_POS || cur_pos == ipd_pkg::COUNT_LO_POS)
                begin
                    rl_next = {cur_rl[7:0], b};
                end
                else if (cur_pos >= ipd_pkg::TAG_FIRST_POS && cur_pos <= ipd_pkg::TAG_LAST_POS)
                begin
                    acc_next = {cur_acc[55:0], b};
                end
                if (cur_pos == ipd_pkg::TAG_LAST_POS)
                begin
                    main_valid             = 1'b1;
                    main_item.item_kind    = ipd_pkg::KIND_HEADER;
                    main_item.record_count = rl_next;
                    main_item.tag_value    = acc_next;
                end
                if (cur_pos >= ipd_pkg::HDR_LAST_POS)
                begin
                    acc_next = '0;
                    rec_next = '0;
                    bl_next  = '0;
                    if (rl_next == 16'd0)
                    begin
                        phase_next = ipd_pkg::PH_DONE;
                        rep_next   = ipd_pkg::DATA_START_POS;
                    end
                    else
                    begin
                        phase_next = ipd_pkg::PH_RECHDR;
                    end
                end
            end
            ipd_pkg::PH_RECHDR:
            begin
                acc_next = {16'd0, cur_acc[39:0], b};
                bl_next  = cur_bl + 16'd1;
                // Offset bytes are all in: divide while the length arrives
                if (cur_bl == ipd_pkg::OFFSET_BYTES)
                begin
                    quot_load = 1'b1;
                end
                if (bl_next >= ipd_pkg::REC_HDR_BYTES)
                begin
                    main_valid              = 1'b1;
                    main_item.item_kind     = ipd_pkg::KIND_RECHDR;
                    main_item.record_index  = cur_rec;
                    main_item.offset_ticks  = quot_reg;
                    main_item.record_length = acc_next[15:0];
                    if (acc_next[15:0] == 16'd0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = ipd_pkg::PH_DATA;
                        bl_next    = acc_next[15:0];
                    end
                end
            end
            ipd_pkg::PH_DATA:
            begin
                if (cur_wa < ipd_pkg::STORE_LIMIT)
                begin
                    main_valid              = 1'b1;
                    main_item.item_kind     = ipd_pkg::KIND_DATA;
                    main_item.record_index  = cur_rec;
                    main_item.record_length = cur_acc[15:0];
                    main_item.data_value    = b;
                    main_item.store_address = cur_wa[15:0];
                    wa_next                 = cur_wa + 17'd1;
                end
                else
                begin
                    wa_next = ipd_pkg::STORE_OVF;
                end
                bl_next = cur_bl - 16'd1;
                if (bl_next == 16'd0)
                begin
                    finish = 1'b1;
                end
            end
            ipd_pkg::PH_DONE:
            begin
                // Drop trailing bytes
            end
        endcase

        if (finish)
        begin
            rl_next  = cur_rl - 16'd1;
            rec_next = cur_rec + 16'd1;
            if (rl_next == 16'd0)
            begin
                phase_next = ipd_pkg::PH_DONE;
                rep_next   = {1'b0, cur_pos} + 17'd1;
            end
            else
            begin
                phase_next = ipd_pkg::PH_RECHDR;
                bl_next    = '0;
                acc_next   = '0;
            end
        end

        end_item.item_kind   = ipd_pkg::KIND_END;
        end_item.last_of_run = 1'b1;
        priority if (wa_next > ipd_pkg::STORE_LIMIT)
        begin
            end_item.status_code = ipd_pkg::ST_OVERFLOW;
        end
        else if (phase_next != ipd_pkg::PH_DONE)
        begin
            end_item.status_code = ipd_pkg::ST_MISMATCH;
        end
        else if ({2'b00, in_req_reg.declared_size} == ({1'b0, rep_next} + ipd_pkg::SIZE_BIAS))
        begin
            end_item.status_code = ipd_pkg::ST_OK;
        end
        else
        begin
            end_item.status_code = ipd_pkg::ST_MISMATCH;
        end

        if (advance)
        begin
            if (main_valid)
            begin
                main_item.last_of_run = ~in_req_reg.final_byte;
                push.first            = main_item;
                push.second           = end_item;
                push.count            = in_req_reg.final_byte ? 2'd2 : 2'd1;
            end
            else if (in_req_reg.final_byte)
            begin
                push.first = end_item;
                push.count = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ipd_pkg::PH_HEADER;
            pos_reg   <= '0;
            rl_reg    <= '0;
            rec_reg   <= '0;
            acc_reg   <= '0;
            bl_reg    <= '0;
            wa_reg    <= '0;
            rep_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            rl_reg    <= rl_next;
            rec_reg   <= rec_next;
            acc_reg   <= acc_next;
            bl_reg    <= bl_next;
            wa_reg    <= wa_next;
            rep_reg   <= rep_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ipd_pkg::PH_DATA |-> bl_reg != 16'd0)
        else $error("data phase with no bytes left in record");

    a_addr_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        wa_reg <= ipd_pkg::STORE_OVF)
        else $error("store address beyond overflow mark");
`endif

endmodule

FILE: hw/rtl/ipd_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_result_fifo: result queue
// Takes up to two result requests a cycle and hands one a cycle to the
// output channel while res_stall is low.
// ----------------------------------------------------------------------------
module ipd_result_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  ipd_pkg::push_t    push,
    output logic              room,
    output logic              res_valid,
    input  logic              res_stall,
    output ipd_pkg::res_req_t res_req
);

    localparam int unsigned PW = ipd_pkg::FIFO_PTR_W;

    ipd_pkg::res_req_t mem_reg [ipd_pkg::FIFO_DEPTH];
    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [PW:0]       count_reg, count_next;
    logic              pop;

    assign res_valid = (count_reg != '0);
    assign res_req   = mem_reg[head_reg];
    assign pop       = res_valid & ~res_stall;
    assign room      = (count_reg <= (PW+1)'(ipd_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        head_next  = head_reg + PW'(pop);
        tail_next  = tail_reg + PW'(push.count);
        count_next = count_reg + (PW+1)'(push.count) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[tail_reg + PW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(ipd_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    a_pair_together: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_req.last_of_run) |-> count_reg >= (PW+1)'(2))
        else $error("first of a pair queued without its partner");
`endif

endmodule
